### rtl/core/hbk_pkg.sv
package hbk_pkg;

  localparam int INPUT_SLOTS = 6;
  localparam int MOD_COUNT = 8;

  localparam logic [7:0] MOD_BASE = 8'hE0;
  localparam logic [7:0] BREAK_BIT = 8'h80;
  localparam logic [7:0] PHANTOM_USAGE = 8'h01;
  localparam logic [7:0] EMPTY_USAGE = 8'h00;

  // One scancode event as it leaves the block.
  typedef struct packed {
    logic       ext;
    logic [7:0] code;
  } evt_t;

  // Usage to set-1 translation. Bit 8 is the E0-prefix flag, bits 7..0 the
  // make code. An all-zero entry means the usage has no scancode.
  function automatic logic [8:0] usage_rom(input logic [7:0] usage);
    logic [8:0] r;
    r = 9'h000;
    case (usage)
      8'h04: r = 9'h01E;  8'h05: r = 9'h030;  8'h06: r = 9'h02E;  8'h07: r = 9'h020;
      8'h08: r = 9'h012;  8'h09: r = 9'h021;  8'h0A: r = 9'h022;  8'h0B: r = 9'h023;
      8'h0C: r = 9'h017;  8'h0D: r = 9'h024;  8'h0E: r = 9'h025;  8'h0F: r = 9'h026;
      8'h10: r = 9'h032;  8'h11: r = 9'h031;  8'h12: r = 9'h018;  8'h13: r = 9'h019;
      8'h14: r = 9'h010;  8'h15: r = 9'h013;  8'h16: r = 9'h01F;  8'h17: r = 9'h014;
      8'h18: r = 9'h016;  8'h19: r = 9'h02F;  8'h1A: r = 9'h011;  8'h1B: r = 9'h02D;
      8'h1C: r = 9'h015;  8'h1D: r = 9'h02C;
      8'h1E: r = 9'h002;  8'h1F: r = 9'h003;  8'h20: r = 9'h004;  8'h21: r = 9'h005;
      8'h22: r = 9'h006;  8'h23: r = 9'h007;  8'h24: r = 9'h008;  8'h25: r = 9'h009;
      8'h26: r = 9'h00A;  8'h27: r = 9'h00B;
      8'h28: r = 9'h01C;  8'h29: r = 9'h001;  8'h2A: r = 9'h00E;  8'h2B: r = 9'h00F;
      8'h2C: r = 9'h039;  8'h2D: r = 9'h00C;  8'h2E: r = 9'h00D;  8'h2F: r = 9'h01A;
      8'h30: r = 9'h01B;  8'h31: r = 9'h02B;
      8'h33: r = 9'h027;  8'h34: r = 9'h028;  8'h35: r = 9'h029;  8'h36: r = 9'h033;
      8'h37: r = 9'h034;  8'h38: r = 9'h035;  8'h39: r = 9'h03A;  8'h3A: r = 9'h03B;
      8'h3B: r = 9'h03C;  8'h3C: r = 9'h03D;  8'h3D: r = 9'h03E;  8'h3E: r = 9'h03F;
      8'h3F: r = 9'h040;  8'h40: r = 9'h041;  8'h41: r = 9'h042;  8'h42: r = 9'h043;
      8'h43: r = 9'h044;  8'h44: r = 9'h057;  8'h45: r = 9'h058;
      8'h46: r = 9'h137;  8'h47: r = 9'h046;
      8'h49: r = 9'h152;  8'h4A: r = 9'h147;  8'h4B: r = 9'h149;  8'h4C: r = 9'h153;
      8'h4D: r = 9'h14F;  8'h4E: r = 9'h151;  8'h4F: r = 9'h14D;  8'h50: r = 9'h14B;
      8'h51: r = 9'h150;  8'h52: r = 9'h148;
      8'h53: r = 9'h045;  8'h54: r = 9'h135;  8'h55: r = 9'h037;  8'h56: r = 9'h04A;
      8'h57: r = 9'h04E;  8'h58: r = 9'h11C;  8'h59: r = 9'h04F;  8'h5A: r = 9'h050;
      8'h5B: r = 9'h051;  8'h5C: r = 9'h04B;  8'h5D: r = 9'h04C;  8'h5E: r = 9'h04D;
      8'h5F: r = 9'h047;  8'h60: r = 9'h048;  8'h61: r = 9'h049;  8'h62: r = 9'h052;
      8'h63: r = 9'h053;
      8'hE0: r = 9'h01D;  8'hE1: r = 9'h02A;  8'hE2: r = 9'h038;  8'hE3: r = 9'h15B;
      8'hE4: r = 9'h11D;  8'hE5: r = 9'h036;  8'hE6: r = 9'h138;  8'hE7: r = 9'h15C;
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/hid_boot_kbd_to_set1_scancodes.sv
// Boot-keyboard report to AT set-1 scancode translator.
// The input channel carries one boot-protocol keyboard report per transfer: a
// report-valid flag, the modifier byte and six key slots. The output channel
// carries one scancode event per transfer: the E0-prefix flag, the set-1 code
// with bit 7 set on a release, and a flag that marks the last event of a report.
// Events of one report come out as modifier changes (bit 0 first), then makes of
// newly pressed keys in slot order, then breaks of released keys in old slot order.
// An invalid report or an ErrorRollOver report is taken and dropped.
// Any other report is taken and in_stall rises while it is worked on. The previous
// keys live in a small synchronous memory that is first read into a working copy,
// one entry a cycle, and then rewritten with the new keys during the event scan.
// With S used slots, a report runs the memory load, then the scan over 8 + 2*S
// candidates, one candidate a cycle while no event waits on a stalled output,
// and last hands the held-back event to the output register, if there is one.
// A stall on the output holds the event register and pauses the scan; nothing
// is lost. A new report is taken once the last event has moved into the output
// register, even while it still waits there.
// Reset clears the previous modifiers and marks every memory entry unwritten, so
// the stored keys read as empty; no clearing pass is needed.
module hid_boot_kbd_to_set1_scancodes
  import hbk_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_report_valid,
  input  logic [7:0] in_modifier_bits,
  input  logic [7:0] in_key_slot_0,
  input  logic [7:0] in_key_slot_1,
  input  logic [7:0] in_key_slot_2,
  input  logic [7:0] in_key_slot_3,
  input  logic [7:0] in_key_slot_4,
  input  logic [7:0] in_key_slot_5,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_extended_prefix,
  output logic [7:0] out_scan_byte,
  output logic       out_last_event
);

  localparam int UsedSlots = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;
  localparam int StoreSlots = KEY_SLOTS;
  localparam int AW = (StoreSlots > 1) ? $clog2(StoreSlots) : 1;
  localparam int SIW = (UsedSlots > 1) ? $clog2(UsedSlots) : 1;
  localparam int LW = $clog2(UsedSlots + 1);
  localparam int CandN = MOD_COUNT + 2 * UsedSlots;
  localparam int CIW = $clog2(CandN + 1);

  localparam logic [CIW-1:0] MOD_END = CIW'(MOD_COUNT);
  localparam logic [CIW-1:0] MAKE_END = CIW'(MOD_COUNT + UsedSlots);
  localparam logic [CIW-1:0] CAND_END = CIW'(CandN);
  localparam logic [CIW-1:0] SLOT_END = CIW'(UsedSlots);
  localparam logic [LW-1:0] LOAD_END = LW'(UsedSlots);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t         state_r;
  logic [LW-1:0]  ld_r;
  logic [CIW-1:0] cand_r;
  logic [7:0]     mods_r;
  logic [7:0]     diff_r;
  logic [7:0]     prev_mods_r;
  logic [7:0]     now_r [UsedSlots];
  logic [7:0]     old_r [UsedSlots];
  logic           pend_v_r;
  evt_t           pend_r;
  logic           out_valid_r;
  evt_t           out_evt_r;
  logic           out_last_r;

  // Previous-key store with one written flag per entry.
  logic [7:0]     mem [StoreSlots];
  logic           vld_r [StoreSlots];
  logic [7:0]     rd_data_r;
  logic           rd_vld_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_wdata;

  logic [7:0]     in_keys [INPUT_SLOTS];
  logic           phantom;
  logic           start;
  logic           out_free;
  logic           out_load;

  logic [2:0]     mod_bit;
  logic [SIW-1:0] slot;
  logic [7:0]     cand_usage;
  logic           cand_make;
  logic           cand_en;
  logic           held_old;
  logic           held_new;
  logic [8:0]     rom_word;
  logic           ev;
  evt_t           cur_evt;

  assign in_keys[0] = in_key_slot_0;
  assign in_keys[1] = in_key_slot_1;
  assign in_keys[2] = in_key_slot_2;
  assign in_keys[3] = in_key_slot_3;
  assign in_keys[4] = in_key_slot_4;
  assign in_keys[5] = in_key_slot_5;

  // A report whose used slots all carry ErrorRollOver is a phantom and is dropped.
  always_comb begin
    phantom = 1'b1;
    for (int i = 0; i < UsedSlots; i++) begin
      if (in_keys[i] != PHANTOM_USAGE) begin
        phantom = 1'b0;
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign start = in_valid && !in_stall && in_report_valid && !phantom;
  assign out_free = !out_valid_r || !out_stall;

  // The held-back event moves to the output register when the scan finds the
  // next event or runs out, and the register is free to take it.
  assign out_load = (state_r == S_EMIT) && pend_v_r && out_free &&
                    ((cand_r == CAND_END) || ev);

  // Memory port control: reads during the load, writes during the first
  // candidates of the scan, when the working copy already holds the old keys.
  always_comb begin
    mem_raddr = (ld_r < LOAD_END) ? AW'(ld_r) : '0;
    mem_we = (state_r == S_EMIT) && (cand_r < SLOT_END);
    mem_waddr = AW'(cand_r);
    mem_wdata = EMPTY_USAGE;
    for (int j = 0; j < UsedSlots; j++) begin
      if (cand_r == CIW'(j)) begin
        mem_wdata = now_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
    rd_vld_r <= vld_r[mem_raddr];
  end

  // Candidate decode: the scan index picks a modifier bit, a new slot or an
  // old slot, and decides whether it gives an event.
  always_comb begin
    mod_bit = cand_r[2:0];
    slot = '0;
    cand_usage = EMPTY_USAGE;
    cand_make = 1'b1;
    cand_en = 1'b0;
    held_old = 1'b0;
    held_new = 1'b0;
    if (cand_r < MOD_END) begin
      cand_usage = MOD_BASE | {5'd0, mod_bit};
      cand_make = mods_r[mod_bit];
      cand_en = diff_r[mod_bit];
    end else if (cand_r < MAKE_END) begin
      slot = SIW'(cand_r - MOD_END);
      for (int j = 0; j < UsedSlots; j++) begin
        if (slot == SIW'(j)) begin
          cand_usage = now_r[j];
        end
      end
      for (int j = 0; j < UsedSlots; j++) begin
        if (old_r[j] == cand_usage) begin
          held_old = 1'b1;
        end
      end
      cand_en = (cand_usage != EMPTY_USAGE) && !held_old;
    end else if (cand_r < CAND_END) begin
      slot = SIW'(cand_r - MAKE_END);
      cand_make = 1'b0;
      for (int j = 0; j < UsedSlots; j++) begin
        if (slot == SIW'(j)) begin
          cand_usage = old_r[j];
        end
      end
      for (int j = 0; j < UsedSlots; j++) begin
        if (now_r[j] == cand_usage) begin
          held_new = 1'b1;
        end
      end
      cand_en = (cand_usage != EMPTY_USAGE) && !held_new;
    end
    rom_word = usage_rom(cand_usage);
    ev = cand_en && (rom_word != 9'h000);
    cur_evt.ext = rom_word[8];
    cur_evt.code = cand_make ? rom_word[7:0] : (rom_word[7:0] | BREAK_BIT);
  end

  // Sequencer. One event is held back in pend_r so that the last one of a
  // report can be flagged once the scan has run out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      prev_mods_r <= 8'h00;
      for (int j = 0; j < StoreSlots; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mods_r <= in_modifier_bits;
            diff_r <= in_modifier_bits ^ prev_mods_r;
            prev_mods_r <= in_modifier_bits;
            for (int j = 0; j < UsedSlots; j++) begin
              now_r[j] <= in_keys[j];
            end
            ld_r <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int j = 0; j < UsedSlots; j++) begin
            if (ld_r == LW'(j + 1)) begin
              old_r[j] <= rd_vld_r ? rd_data_r : EMPTY_USAGE;
            end
          end
          if (ld_r == LOAD_END) begin
            cand_r <= '0;
            state_r <= S_EMIT;
          end else begin
            ld_r <= ld_r + LW'(1);
          end
        end
        S_EMIT: begin
          if (cand_r != CAND_END) begin
            if (ev) begin
              if (!pend_v_r) begin
                pend_r <= cur_evt;
                pend_v_r <= 1'b1;
                cand_r <= cand_r + CIW'(1);
              end else if (out_free) begin
                out_evt_r <= pend_r;
                out_last_r <= 1'b0;
                pend_r <= cur_evt;
                cand_r <= cand_r + CIW'(1);
              end
            end else begin
              cand_r <= cand_r + CIW'(1);
            end
          end else if (pend_v_r) begin
            if (out_free) begin
              out_evt_r <= pend_r;
              out_last_r <= 1'b1;
              pend_v_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_extended_prefix = out_evt_r.ext;
  assign out_scan_byte = out_evt_r.code;
  assign out_last_event = out_last_r;

endmodule

### rtl/core/hbk_checker.sv
module hbk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_report_valid,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_extended_prefix,
  input logic [7:0] out_scan_byte,
  input logic       out_last_event
);

  // A stalled event holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scan_byte)
      && $stable(out_extended_prefix) && $stable(out_last_event))
    else $error("stalled output event changed");

  // An invalid report is dropped and leaves the block ready.
  a_drop_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_report_valid |=> !in_stall)
    else $error("invalid report made the block busy");

  // An invalid report taken with an empty output gives no event.
  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_report_valid && !out_valid |=> !out_valid)
    else $error("invalid report produced an event");

  // Events are only loaded while a report is being worked on.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("event appeared while the block was idle");

endmodule

bind hid_boot_kbd_to_set1_scancodes hbk_checker u_hbk_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_report_valid     (in_report_valid),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_extended_prefix (out_extended_prefix),
  .out_scan_byte       (out_scan_byte),
  .out_last_event      (out_last_event)
);
